// ----- sv/hrsp_pkg.sv -----
// ============================================================================
// hrsp_pkg: shared types and constants of the HTTP response stream parser
// Word layouts of both channels, the phase codes, error codes, character
// constants and the header key tables used by the byte classifier.
// ============================================================================
package hrsp_pkg;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       restart;
	} in_t;

	typedef struct packed {
		logic        body_valid;
		logic [7:0]  body_byte;
		logic        header_done;
		logic        message_done;
		logic [9:0]  resp_code;
		logic [31:0] content_length;
		logic        length_present;
		logic        is_chunked;
		logic [1:0]  error_code;
	} out_t;

	typedef enum logic [7:0] {
		PH_STATUS  = 8'b0000_0001,
		PH_KEY     = 8'b0000_0010,
		PH_VALUE   = 8'b0000_0100,
		PH_LENBODY = 8'b0000_1000,
		PH_CHSIZE  = 8'b0001_0000,
		PH_CHEXT   = 8'b0010_0000,
		PH_CHDATA  = 8'b0100_0000,
		PH_CLOSE   = 8'b1000_0000
	} phase_t;

	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_SYNTAX   = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	localparam logic [2:0] FS_IDLE = 3'd0;
	localparam logic [2:0] FS_ONE  = 3'd1;
	localparam logic [2:0] FS_TWO  = 3'd2;
	localparam logic [2:0] FS_DONE = 3'd3;

	localparam logic [1:0] CAND_CL   = 2'b01;
	localparam logic [1:0] CAND_TE   = 2'b10;
	localparam logic [1:0] CAND_BOTH = 2'b11;

	localparam logic [4:0] KEY_CL_LEN = 5'd14;
	localparam logic [4:0] KEY_TE_LEN = 5'd17;
	localparam logic [4:0] IDX_MAX    = 5'd31;
	localparam logic [2:0] WORD_LEN   = 3'd7;
	localparam logic [9:0] CODE_MAX   = 10'd999;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [4:0] HEX_NONE = 5'd16;

	function automatic logic [7:0] lower_case(logic [7:0] c);
		return (c inside {["A":"Z"]}) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_dec(logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_ows(logic [7:0] c);
		return c inside {CH_SP, CH_TAB};
	endfunction

	// Returns HEX_NONE for a byte that is not a hex digit.
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [7:0] lc;
		lc = lower_case(c);
		if (is_dec(c))
			return 5'(c - "0");
		else if (lc inside {["a":"f"]})
			return 5'(lc - "a" + 8'd10);
		else
			return HEX_NONE;
	endfunction

	function automatic logic [1:0] merge_err(logic [1:0] cur, logic [1:0] e);
		return (cur == ERR_OK) ? e : cur;
	endfunction

	function automatic logic [7:0] key_cl_char(logic [4:0] i);
		case (i)
			5'd0:    return "c";
			5'd1:    return "o";
			5'd2:    return "n";
			5'd3:    return "t";
			5'd4:    return "e";
			5'd5:    return "n";
			5'd6:    return "t";
			5'd7:    return "-";
			5'd8:    return "l";
			5'd9:    return "e";
			5'd10:   return "n";
			5'd11:   return "g";
			5'd12:   return "t";
			5'd13:   return "h";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] key_te_char(logic [4:0] i);
		case (i)
			5'd0:    return "t";
			5'd1:    return "r";
			5'd2:    return "a";
			5'd3:    return "n";
			5'd4:    return "s";
			5'd5:    return "f";
			5'd6:    return "e";
			5'd7:    return "r";
			5'd8:    return "-";
			5'd9:    return "e";
			5'd10:   return "n";
			5'd11:   return "c";
			5'd12:   return "o";
			5'd13:   return "d";
			5'd14:   return "i";
			5'd15:   return "n";
			5'd16:   return "g";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] chunked_char(logic [2:0] i);
		case (i)
			3'd0:    return "c";
			3'd1:    return "h";
			3'd2:    return "u";
			3'd3:    return "n";
			3'd4:    return "k";
			3'd5:    return "e";
			3'd6:    return "d";
			default: return 8'h00;
		endcase
	endfunction

endpackage

// ----- sv/hrsp_skid.sv -----
// ============================================================================
// hrsp_skid: result register with skid stage
// Holds up to two result words so that a new byte can be taken while a
// finished result still waits downstream.
// ============================================================================
module hrsp_skid (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  hrsp_pkg::out_t  push_data,
	output logic            push_full,
	output logic            pop_valid,
	input  logic            pop_stall,
	output hrsp_pkg::out_t  pop_data
);

	logic           main_v_q;
	logic           skid_v_q;
	hrsp_pkg::out_t main_d_q;
	hrsp_pkg::out_t skid_d_q;
	logic           main_free;

	assign main_free = !main_v_q || !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push_valid;
			end
		end else if (push_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_d_q <= skid_v_q ? skid_d_q : push_data;
		end else if (push_valid && !skid_v_q) begin
			skid_d_q <= push_data;
		end
	end

	assign push_full = skid_v_q;
	assign pop_valid = main_v_q;
	assign pop_data  = main_d_q;

endmodule

// ----- sv/http_response_stream_parser_core.sv -----
// ============================================================================
// http_response_stream_parser_core: HTTP/1.1 response byte parser
// Each accepted byte yields one result word, held in the result register or, while
// that register stalls, in the skid stage. Throughput: one byte per cycle while
// byte_stall is low; byte_stall rises only when both result register and skid
// stage hold words. Reset clears the parser state, the sticky error and the
// output channel at once.
// ============================================================================
module http_response_stream_parser_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  hrsp_pkg::in_t   byte_data,
	output logic            result_valid,
	input  logic            result_stall,
	output hrsp_pkg::out_t  result_data
);

	localparam int WB = LENGTH_BITS + 4;

	typedef struct packed {
		hrsp_pkg::phase_t       ph;
		logic [2:0]             fs;
		logic [4:0]             kmi;
		logic [1:0]             kc;
		logic [2:0]             vmi;
		logic [LENGTH_BITS-1:0] acc;
		logic                   scr;
		logic                   lie;
		logic [9:0]             code;
		logic [LENGTH_BITS-1:0] len;
		logic                   lseen;
		logic                   chk;
		logic [LENGTH_BITS-1:0] bl;
		logic [1:0]             err;
	} st_t;

	function automatic st_t st_reset();
		st_t s;
		s.ph    = hrsp_pkg::PH_STATUS;
		s.fs    = hrsp_pkg::FS_IDLE;
		s.kmi   = '0;
		s.kc    = hrsp_pkg::CAND_BOTH;
		s.vmi   = '0;
		s.acc   = '0;
		s.scr   = 1'b0;
		s.lie   = 1'b1;
		s.code  = '0;
		s.len   = '0;
		s.lseen = 1'b0;
		s.chk   = 1'b0;
		s.bl    = '0;
		s.err   = hrsp_pkg::ERR_OK;
		return s;
	endfunction

	function automatic logic [WB-1:0] times10_plus(logic [LENGTH_BITS-1:0] a, logic [7:0] c);
		logic [WB-1:0] w;
		w = {4'b0000, a};
		return (w << 3) + (w << 1) + WB'(c - "0");
	endfunction

	// One ordinary byte of the status line or of a header line.
	function automatic st_t line_char(st_t s_in, logic [7:0] c);
		st_t           s;
		logic [7:0]    lc;
		logic [WB-1:0] w;
		s  = s_in;
		lc = hrsp_pkg::lower_case(c);
		w  = times10_plus(s.acc, c);
		s.lie = 1'b0;
		if (s.ph == hrsp_pkg::PH_STATUS) begin
			if (s.fs == hrsp_pkg::FS_IDLE) begin
				if (c == hrsp_pkg::CH_SP)
					s.fs = hrsp_pkg::FS_ONE;
			end else if (s.fs == hrsp_pkg::FS_ONE) begin
				if (hrsp_pkg::is_dec(c)) begin
					s.acc = LENGTH_BITS'(c - "0");
					s.fs  = hrsp_pkg::FS_TWO;
				end else begin
					s.err = hrsp_pkg::merge_err(s.err, hrsp_pkg::ERR_SYNTAX);
					s.fs  = hrsp_pkg::FS_DONE;
				end
			end else if (s.fs == hrsp_pkg::FS_TWO) begin
				if (hrsp_pkg::is_dec(c)) begin
					if (w > WB'(hrsp_pkg::CODE_MAX)) begin
						s.err = hrsp_pkg::merge_err(s.err, hrsp_pkg::ERR_OVERFLOW);
						s.acc = LENGTH_BITS'(hrsp_pkg::CODE_MAX);
					end else begin
						s.acc = w[LENGTH_BITS-1:0];
					end
				end else if (c == hrsp_pkg::CH_SP) begin
					s.code = s.acc[9:0];
					s.fs   = hrsp_pkg::FS_DONE;
				end else begin
					s.err = hrsp_pkg::merge_err(s.err, hrsp_pkg::ERR_SYNTAX);
					s.fs  = hrsp_pkg::FS_DONE;
				end
			end
		end else if (s.ph == hrsp_pkg::PH_KEY) begin
			if (c == hrsp_pkg::CH_COLON) begin
				s.kc  = s.kc & {s.kmi == hrsp_pkg::KEY_TE_LEN, s.kmi == hrsp_pkg::KEY_CL_LEN};
				s.ph  = hrsp_pkg::PH_VALUE;
				s.fs  = hrsp_pkg::FS_IDLE;
				s.vmi = '0;
				s.acc = '0;
			end else begin
				if (s.kmi >= hrsp_pkg::KEY_CL_LEN || lc != hrsp_pkg::key_cl_char(s.kmi))
					s.kc = s.kc & ~hrsp_pkg::CAND_CL;
				if (s.kmi >= hrsp_pkg::KEY_TE_LEN || lc != hrsp_pkg::key_te_char(s.kmi))
					s.kc = s.kc & ~hrsp_pkg::CAND_TE;
				if (s.kmi != hrsp_pkg::IDX_MAX)
					s.kmi = s.kmi + 5'd1;
			end
		end else if (s.fs != hrsp_pkg::FS_DONE) begin
			if ((s.kc & hrsp_pkg::CAND_CL) != '0) begin
				if (hrsp_pkg::is_ows(c)) begin
					if (s.fs == hrsp_pkg::FS_ONE)
						s.fs = hrsp_pkg::FS_TWO;
				end else if (hrsp_pkg::is_dec(c) && s.fs == hrsp_pkg::FS_IDLE) begin
					s.acc = LENGTH_BITS'(c - "0");
					s.fs  = hrsp_pkg::FS_ONE;
				end else if (hrsp_pkg::is_dec(c) && s.fs == hrsp_pkg::FS_ONE) begin
					if (w[WB-1:LENGTH_BITS] != '0) begin
						s.err = hrsp_pkg::merge_err(s.err, hrsp_pkg::ERR_OVERFLOW);
						s.acc = '1;
					end else begin
						s.acc = w[LENGTH_BITS-1:0];
					end
				end else begin
					s.err = hrsp_pkg::merge_err(s.err, hrsp_pkg::ERR_SYNTAX);
					s.fs  = hrsp_pkg::FS_DONE;
				end
			end else if ((s.kc & hrsp_pkg::CAND_TE) != '0) begin
				if (hrsp_pkg::is_ows(c)) begin
					if (s.fs == hrsp_pkg::FS_ONE)
						s.fs = hrsp_pkg::FS_TWO;
				end else if (s.fs == hrsp_pkg::FS_TWO || s.vmi >= hrsp_pkg::WORD_LEN ||
						lc != hrsp_pkg::chunked_char(s.vmi)) begin
					s.fs = hrsp_pkg::FS_DONE;
				end else begin
					s.vmi = s.vmi + 3'd1;
					s.fs  = hrsp_pkg::FS_ONE;
				end
			end
		end
		return s;
	endfunction

	st_t              st_q;
	st_t              st_d;
	hrsp_pkg::out_t   res_d;
	logic             accept;
	logic             skid_full;

	assign accept     = byte_valid && !byte_stall;
	assign byte_stall = skid_full;

	always_comb begin
		st_t              s;
		st_t              n;
		logic [7:0]       c;
		logic [4:0]       h;
		logic             nl;
		hrsp_pkg::phase_t nl_ph;
		logic             msg;
		logic             hdr;
		logic             bv;
		logic [63:0]      len_ext;
		s     = byte_data.restart ? st_reset() : st_q;
		c     = byte_data.rx_byte;
		h     = hrsp_pkg::hex_val(c);
		n     = s;
		nl    = 1'b0;
		nl_ph = hrsp_pkg::PH_STATUS;
		msg   = 1'b0;
		hdr   = 1'b0;
		bv    = 1'b0;
		case (s.ph)
			hrsp_pkg::PH_STATUS, hrsp_pkg::PH_KEY, hrsp_pkg::PH_VALUE: begin
				n.scr = 1'b0;
				if (s.scr && c == hrsp_pkg::CH_LF) begin
					nl    = 1'b1;
					nl_ph = hrsp_pkg::PH_KEY;
					if (s.ph == hrsp_pkg::PH_STATUS) begin
						if (s.lie) begin
							// Empty lines ahead of the status line are dropped.
							nl_ph = hrsp_pkg::PH_STATUS;
						end else if (s.fs < hrsp_pkg::FS_TWO) begin
							n.err = hrsp_pkg::merge_err(s.err, hrsp_pkg::ERR_SYNTAX);
						end else if (s.fs == hrsp_pkg::FS_TWO) begin
							n.code = s.acc[9:0];
						end
					end else if (s.ph == hrsp_pkg::PH_KEY) begin
						if (s.lie) begin
							hdr = 1'b1;
							if (s.chk) begin
								nl_ph = hrsp_pkg::PH_CHSIZE;
							end else if (s.lseen) begin
								if (s.len == '0) begin
									nl  = 1'b0;
									msg = 1'b1;
								end else begin
									n.bl  = s.len;
									nl_ph = hrsp_pkg::PH_LENBODY;
								end
							end else begin
								nl_ph = hrsp_pkg::PH_CLOSE;
							end
						end
					end else begin
						if ((s.kc & hrsp_pkg::CAND_CL) != '0) begin
							if (s.fs == hrsp_pkg::FS_IDLE) begin
								n.err = hrsp_pkg::merge_err(s.err, hrsp_pkg::ERR_SYNTAX);
							end else if ((s.fs inside {hrsp_pkg::FS_ONE, hrsp_pkg::FS_TWO}) &&
									!s.lseen) begin
								n.len   = s.acc;
								n.lseen = 1'b1;
							end
						end else if ((s.kc & hrsp_pkg::CAND_TE) != '0) begin
							if ((s.fs inside {hrsp_pkg::FS_ONE, hrsp_pkg::FS_TWO}) &&
									s.vmi == hrsp_pkg::WORD_LEN)
								n.chk = 1'b1;
						end
					end
				end else begin
					// A CR that was not followed by LF is an ordinary line byte.
					if (s.scr)
						n = line_char(n, hrsp_pkg::CH_CR);
					if (c == hrsp_pkg::CH_CR)
						n.scr = 1'b1;
					else
						n = line_char(n, c);
				end
			end
			hrsp_pkg::PH_LENBODY, hrsp_pkg::PH_CHDATA: begin
				bv = 1'b1;
				if (s.bl != '0)
					n.bl = s.bl - 1'b1;
				if (n.bl == '0) begin
					if (s.ph == hrsp_pkg::PH_LENBODY) begin
						msg = 1'b1;
					end else begin
						nl    = 1'b1;
						nl_ph = hrsp_pkg::PH_CHSIZE;
					end
				end
			end
			hrsp_pkg::PH_CHSIZE: begin
				if (s.fs == hrsp_pkg::FS_IDLE) begin
					if (c == hrsp_pkg::CH_CR || c == hrsp_pkg::CH_LF) begin
						n = s;
					end else if (h != hrsp_pkg::HEX_NONE) begin
						n.acc = LENGTH_BITS'(h[3:0]);
						n.fs  = hrsp_pkg::FS_ONE;
					end else begin
						// A bad size line is taken as size zero.
						n.err = hrsp_pkg::merge_err(s.err, hrsp_pkg::ERR_SYNTAX);
						n.acc = '0;
						n.ph  = hrsp_pkg::PH_CHEXT;
					end
				end else if (h != hrsp_pkg::HEX_NONE) begin
					if (s.acc[LENGTH_BITS-1 -: 4] != 4'h0) begin
						n.err = hrsp_pkg::merge_err(s.err, hrsp_pkg::ERR_OVERFLOW);
						n.acc = '1;
					end else begin
						n.acc = {s.acc[LENGTH_BITS-5:0], h[3:0]};
					end
				end else begin
					n.ph  = hrsp_pkg::PH_CHEXT;
					n.scr = (c == hrsp_pkg::CH_CR);
				end
			end
			hrsp_pkg::PH_CHEXT: begin
				if (s.scr && c == hrsp_pkg::CH_LF) begin
					n.scr = 1'b0;
					if (s.acc == '0) begin
						msg = 1'b1;
					end else begin
						n.bl  = s.acc;
						nl    = 1'b1;
						nl_ph = hrsp_pkg::PH_CHDATA;
					end
				end else begin
					n.scr = (c == hrsp_pkg::CH_CR);
				end
			end
			hrsp_pkg::PH_CLOSE: begin
				bv = 1'b1;
			end
			default: begin
				n = st_reset();
			end
		endcase

		if (nl) begin
			n.ph  = nl_ph;
			n.fs  = hrsp_pkg::FS_IDLE;
			n.kmi = '0;
			n.kc  = hrsp_pkg::CAND_BOTH;
			n.vmi = '0;
			n.acc = '0;
			n.scr = 1'b0;
			n.lie = 1'b1;
		end

		len_ext = 64'(n.len);
		res_d.body_valid     = bv;
		res_d.body_byte      = bv ? c : 8'h00;
		res_d.header_done    = hdr;
		res_d.message_done   = msg;
		res_d.resp_code      = n.code;
		res_d.content_length = (len_ext[63:32] != '0) ? 32'hFFFF_FFFF : len_ext[31:0];
		res_d.length_present = n.lseen;
		res_d.is_chunked     = n.chk;
		res_d.error_code     = n.err;

		// The per-response values are cleared only after the ending word shows them.
		if (msg) begin
			st_d     = st_reset();
			st_d.err = n.err;
		end else begin
			st_d = n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= st_reset();
		end else if (accept) begin
			st_q <= st_d;
		end
	end

	hrsp_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (accept),
		.push_data  (res_d),
		.push_full  (skid_full),
		.pop_valid  (result_valid),
		.pop_stall  (result_stall),
		.pop_data   (result_data)
	);

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> result_valid)
		else $error("input stalled while no result word is held");

	a_message_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_d.message_done) |=>
		(st_q.ph == hrsp_pkg::PH_STATUS && !st_q.lseen && !st_q.chk && st_q.bl == '0))
		else $error("parser not back at the status line after a message end");

	a_header_end_framing: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_d.header_done && !res_d.message_done) |=>
		(st_q.ph == hrsp_pkg::PH_CHSIZE || st_q.ph == hrsp_pkg::PH_LENBODY ||
		 st_q.ph == hrsp_pkg::PH_CLOSE))
		else $error("header end did not select a body framing");

endmodule
